// ----- hw/rtl/uks_pkg.sv -----
// Shared types and codes for the unique-key stack.
// No dependencies; every other file of the block imports this package.
package uks_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W = 5;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_PUSHED    = 3'd0;
    localparam t_status ST_DUPLICATE = 3'd1;
    localparam t_status ST_POPPED    = 3'd2;
    localparam t_status ST_UNDERFLOW = 3'd3;
    localparam t_status ST_FULL      = 3'd4;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // One stored pair.
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } t_entry;

    // Per-cycle control broadcast to every cell of the chain.
    typedef struct packed {
        logic cmp;
        logic push;
        logic pop;
    } t_cell_ctl;

endpackage

// ----- hw/rtl/uks_if.sv -----
// Handshake interfaces for the command and result channels of the stack.
// Depends on uks_pkg for field widths and the status type.
interface uks_cmd_if
    import uks_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    command;
    logic signed [KEY_W-1:0] entry_key;
    logic signed [VAL_W-1:0] entry_value;

    modport source (output valid, output command, output entry_key, output entry_value,
                    input ready);
    modport sink   (input valid, input command, input entry_key, input entry_value,
                    output ready);
endinterface

interface uks_res_if
    import uks_pkg::*;
();
    logic                    valid;
    logic                    ready;
    t_status                 status;
    logic signed [KEY_W-1:0] popped_key;
    logic signed [VAL_W-1:0] popped_value;
    logic [COUNT_W-1:0]      entry_count;
    logic                    stack_empty;

    modport source (output valid, output status, output popped_key, output popped_value,
                    output entry_count, output stack_empty, input ready);
    modport sink   (input valid, input status, input popped_key, input popped_value,
                    input entry_count, input stack_empty, output ready);
endinterface

// ----- hw/rtl/uks_cell.sv -----
// One cell of the stack chain: holds a pair, shifts it toward or away from
// the top, and registers whether its key matches the probe key. Uses uks_pkg.
module uks_cell
    import uks_pkg::*;
(
    input  logic                    i_clk,
    input  t_cell_ctl               i_ctl,
    input  logic                    i_held,
    input  logic signed [KEY_W-1:0] i_cmp_key,
    input  t_entry                  i_above,
    input  t_entry                  i_below,
    output t_entry                  o_entry,
    output logic                    o_hit
);

    t_entry r_entry;
    logic   r_hit;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_hit <= i_held && (r_entry.key == i_cmp_key);
        end
        if (i_ctl.push) begin
            r_entry <= i_above;
        end else if (i_ctl.pop) begin
            r_entry <= i_below;
        end
    end

    assign o_entry = r_entry;
    assign o_hit   = r_hit;

endmodule

// ----- hw/rtl/unique_key_stack.sv -----
// Unique-key LIFO stack: each cell registers its key match at the accepting edge; the result is
// registered when the decision state that shifts the chain completes, once the result register
// is free or drains, so a result held by the sink delays that decision. No new transaction is
// accepted until the decision completes.
// Synchronous active-low reset clears the count, the control state and the result valid; the
// stored pairs are not cleared and are read only after they are written.
module unique_key_stack
    import uks_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    uks_cmd_if.sink  i_cmd,
    uks_res_if.source o_res
);

    // The count must be able to hold DEPTH itself.
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_CHECK = 1'b1;

    // Control state and the captured transaction.
    logic                    r_state;
    logic                    n_state;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic                    r_cmd;
    t_entry                  r_in;

    // Registered result.
    logic                    r_out_valid;
    t_status                 r_out_status;
    t_entry                  r_out_pair;
    logic [COUNT_W-1:0]      r_out_count;
    logic                    r_out_empty;

    // Chain wiring.
    t_cell_ctl               w_ctl;
    t_entry                  w_entry [DEPTH];
    logic [DEPTH-1:0]        w_hit;
    logic [DEPTH-1:0]        w_held;
    logic                    w_accept;
    logic                    w_finish;
    logic                    w_dup;
    logic                    w_full;
    logic                    w_empty;
    t_status                 w_status;
    logic [31:0]             w_count_ext;

    // A new transaction is taken only in the idle state; the captured key
    // is compared against every held cell in that same edge.
    assign i_cmd.ready = (r_state == S_IDLE);
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    // The decision cycle completes once the result register is free or drains.
    assign w_finish = (r_state == S_CHECK) && (!r_out_valid || o_res.ready);

    assign w_dup   = |w_hit;
    assign w_full  = (r_count == CW'(DEPTH));
    assign w_empty = (r_count == '0);

    // Duplicate check comes first, then the full check for pushes.
    always_comb begin
        w_status = ST_PUSHED;
        w_ctl    = '0;
        n_count  = r_count;
        w_ctl.cmp = w_accept;
        if (r_cmd == CMD_PUSH) begin
            if (w_dup) begin
                w_status = ST_DUPLICATE;
            end else if (w_full) begin
                w_status = ST_FULL;
            end else begin
                w_status   = ST_PUSHED;
                w_ctl.push = w_finish;
                n_count    = r_count + CW'(1);
            end
        end else begin
            if (w_empty) begin
                w_status = ST_UNDERFLOW;
            end else begin
                w_status  = ST_POPPED;
                w_ctl.pop = w_finish;
                n_count   = r_count - CW'(1);
            end
        end
    end

    assign w_count_ext = 32'(n_count);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (w_finish) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_finish) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd      <= i_cmd.command;
            r_in.key   <= i_cmd.entry_key;
            r_in.value <= i_cmd.entry_value;
        end
        if (w_finish) begin
            r_out_status <= w_status;
            r_out_pair   <= (w_status == ST_POPPED) ? w_entry[0] : '0;
            r_out_count  <= w_count_ext[COUNT_W-1:0];
            r_out_empty  <= (n_count == '0);
        end
    end

    // Cell 0 is the top of the stack. A push moves every pair one cell
    // deeper and loads the new pair into cell 0; a pop moves every pair
    // one cell up. The deepest cell refills from itself on a pop, which
    // is harmless since it then lies beyond the count.
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        t_entry w_above;
        t_entry w_below;

        assign w_held[gi] = (CW'(gi) < r_count);

        if (gi == 0) begin : g_top
            assign w_above = r_in;
        end else begin : g_mid
            assign w_above = w_entry[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_bottom
            assign w_below = w_entry[gi];
        end else begin : g_inner
            assign w_below = w_entry[gi+1];
        end

        uks_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_held    (w_held[gi]),
            .i_cmp_key (i_cmd.entry_key),
            .i_above   (w_above),
            .i_below   (w_below),
            .o_entry   (w_entry[gi]),
            .o_hit     (w_hit[gi])
        );
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_out_status;
    assign o_res.popped_key   = r_out_pair.key;
    assign o_res.popped_value = r_out_pair.value;
    assign o_res.entry_count  = r_out_count;
    assign o_res.stack_empty  = r_out_empty;

    // The count never passes the capacity of the chain.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("stack count exceeds capacity");

    // An accepted transaction always reaches the decision state next.
    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_CHECK))
        else $error("accepted transaction did not enter decision state");

    // A completed decision always leaves a valid result behind.
    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |=> r_out_valid)
        else $error("decision completed without a result");

    // A successful pop lowers the count by exactly one.
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_finish && r_cmd == CMD_POP && !w_empty) |=> (r_count == $past(r_count) - CW'(1)))
        else $error("pop did not lower the count by one");

    // A rejected push leaves the count unchanged.
    a_reject_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_finish && r_cmd == CMD_PUSH && (w_dup || w_full)) |=> $stable(r_count))
        else $error("rejected push changed the count");

endmodule
